FILE: rtl/odf_pkg.sv
// ----------------------------------------------------------------------------
// odf_pkg
// Shared widths and the command and status words that pass between the
// controller and the datapath of the duplicate filter.
// ----------------------------------------------------------------------------
package odf_pkg;

    localparam int VALUE_W  = 32;
    localparam int UCOUNT_W = 7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // latch a new word and restart the scan
        logic scan;     // issue the next table read, compare returned data
        logic finish;   // store if new, update count, register the result
    } odf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hit;        // word already found in the table
        logic scan_done;  // all stored entries read and compared
    } odf_stat_t;

endpackage

FILE: rtl/odf_ctrl.sv
// ----------------------------------------------------------------------------
// odf_ctrl
// Controller for the duplicate filter: sequences load, table scan and finish.
// ----------------------------------------------------------------------------
module odf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  odf_pkg::odf_stat_t stat,
    output odf_pkg::odf_cmd_t cmd,
    output logic              busy
);
    import odf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.hit || stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands
    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && start;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.finish = (state_reg == ST_FINISH);
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: rtl/odf_dp.sv
// ----------------------------------------------------------------------------
// odf_dp
// Datapath for the duplicate filter: entry memory, scan pointer, comparator,
// entry count and result registers.
// ----------------------------------------------------------------------------
module odf_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  odf_pkg::odf_cmd_t                    cmd,
    output odf_pkg::odf_stat_t                   stat,
    input  logic signed [odf_pkg::VALUE_W-1:0]   value,
    input  logic                                 last,
    output logic                                 result_valid,
    output logic signed [odf_pkg::VALUE_W-1:0]   value_out,
    output logic                                 is_unique,
    output logic [odf_pkg::UCOUNT_W-1:0]         unique_count,
    output logic                                 overflow,
    output logic                                 last_out
);
    import odf_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

    logic signed [VALUE_W-1:0] value_reg;
    logic                      last_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      rd_valid_reg;
    logic                      hit_reg;

    logic                      issue;
    logic                      match;
    logic                      is_new;
    logic                      full;
    logic                      store;
    logic [CNT_W-1:0]          count_after;
    logic [CNT_W+UCOUNT_W-1:0] count_ext;

    // Compare returned data and decide whether to issue another read
    assign issue  = cmd.scan && (idx_reg < count_reg);
    assign match  = cmd.scan && rd_valid_reg && (rd_data_reg == value_reg);
    assign is_new = !hit_reg;
    assign full   = (count_reg == CNT_FULL);
    assign store  = is_new && !full;
    assign count_after = store ? count_reg + CNT_ONE : count_reg;
    assign count_ext   = {{UCOUNT_W{1'b0}}, count_after};

    always_comb
    begin
        stat.hit       = hit_reg || match;
        stat.scan_done = !(idx_reg < count_reg) && !rd_valid_reg;
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.finish && store)
        begin
            mem[count_reg[ADDR_W-1:0]] <= value_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // Hold the word under test
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
            last_reg  <= last;
        end
    end

    // Advance the scan pointer and track hits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (cmd.scan)
        begin
            rd_valid_reg <= issue;
            hit_reg      <= hit_reg || match;
            if (issue)
            begin
                idx_reg <= idx_reg + CNT_ONE;
            end
        end
        else
        begin
            rd_valid_reg <= 1'b0;
        end
    end

    // Update the entry count; clear it after the last word of a set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.finish)
        begin
            count_reg <= last_reg ? '0 : count_after;
        end
    end

    // Register the result and pulse the strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            value_out    <= value_reg;
            is_unique    <= store;
            unique_count <= count_ext[UCOUNT_W-1:0];
            overflow     <= is_new && full;
            last_out     <= last_reg;
        end
    end

endmodule

FILE: rtl/order_preserving_dedup_filter.sv
// ----------------------------------------------------------------------------
// order_preserving_dedup_filter
// Streams the words of a set and flags each one that is seen for the first
// time, keeping the distinct words in a table in order of first arrival.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The block then reads
// the stored entries one per cycle through the single read port of the entry
// memory and stops early on a match; a word that matches none of the entries
// stored so far in the set is compared with all of them. result_valid marks
// the result on the result ports for exactly one cycle, in the cycle busy
// falls; the receiver must take it then, as there is no way to hold it off.
// A new word that meets a full table is flagged overflow and is not stored.
// The table empties after a word with last set; unique_count carries the low
// 7 bits of the count.
module order_preserving_dedup_filter #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [odf_pkg::VALUE_W-1:0]  value,
    input  logic                                last,
    output logic                                result_valid,
    output logic signed [odf_pkg::VALUE_W-1:0]  value_out,
    output logic                                is_unique,
    output logic [odf_pkg::UCOUNT_W-1:0]        unique_count,
    output logic                                overflow,
    output logic                                last_out
);
    import odf_pkg::*;

    odf_cmd_t  cmd;
    odf_stat_t stat;

    odf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    odf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .value_out    (value_out),
        .is_unique    (is_unique),
        .unique_count (unique_count),
        .overflow     (overflow),
        .last_out     (last_out)
    );

endmodule

FILE: rtl/odf_checker.sv
// ----------------------------------------------------------------------------
// odf_checker
// Port-level checks on the duplicate filter's command and result timing.
// ----------------------------------------------------------------------------
module odf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               result_valid,
    input logic                               is_unique,
    input logic [odf_pkg::UCOUNT_W-1:0]       unique_count,
    input logic                               overflow
);
    import odf_pkg::*;

    // An accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted word");

    // A result is never shown while a word is in work
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // No result in the cycle right after a word is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result strobe right after accept");

    // A word is never both stored and overflowed
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(is_unique && overflow))
        else $error("is_unique and overflow both set");

    // A stored word counts at least itself
    a_unique_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_unique) |-> (unique_count != '0))
        else $error("unique word reported with zero count");

endmodule

bind order_preserving_dedup_filter odf_checker u_odf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .is_unique    (is_unique),
    .unique_count (unique_count),
    .overflow     (overflow)
);

FILE: tb/sv/tb_order_preserving_dedup_filter.sv
// ----------------------------------------------------------------------------
// tb_order_preserving_dedup_filter
// Self-checking bench for the order-preserving duplicate filter. A short
// directed pass covers the value extremes, repeats and one-word sets. Random
// sets follow: mostly short ones with frequent repeats and a share of long
// ones that fill the table and run into overflow. A tracker object keeps its
// own copy of the distinct-word table, predicts every result and checks it
// field by field as the strobe fires.
// ----------------------------------------------------------------------------
module tb_order_preserving_dedup_filter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 64;
    localparam int WORD_TARGET  = 1950;
    localparam int QUIET_TAIL   = 200;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam logic signed [odf_pkg::VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [odf_pkg::VALUE_W-1:0] MOST_POS = 32'sh7fff_ffff;

    typedef logic signed [odf_pkg::VALUE_W-1:0] word_t;

    typedef struct {
        word_t                        value;
        logic                         uniq;
        logic [odf_pkg::UCOUNT_W-1:0] ucount;
        logic                         ovf;
        logic                         lst;
    } dedup_result_t;

    // Tracks the distinct words of the current set and the results owed
    class dedup_tracker;
        word_t         entries[TABLE_DEPTH];
        int            stored;
        dedup_result_t owed[$];
        int            mismatches;

        function new();
            stored     = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Predict the result of an accepted word and update the table
        function void note_word(word_t v, logic l);
            dedup_result_t r;
            bit            hit;
            int            i;
            hit = 0;
            for (i = 0; i < stored; i++)
                if (entries[i] == v)
                    hit = 1;
            r.value = v;
            r.uniq  = 1'b0;
            r.ovf   = 1'b0;
            r.lst   = l;
            if (!hit) begin
                if (stored < TABLE_DEPTH) begin
                    entries[stored] = v;
                    stored++;
                    r.uniq = 1'b1;
                end
                else begin
                    r.ovf = 1'b1;
                end
            end
            r.ucount = odf_pkg::UCOUNT_W'(stored);
            // empty the table once the set ends
            if (l)
                stored = 0;
            owed.push_back(r);
        endfunction

        // Compare one strobed result with the oldest prediction
        function void check_result(word_t v, logic u, logic [odf_pkg::UCOUNT_W-1:0] c,
                                   logic o, logic l);
            dedup_result_t e;
            if (owed.size() == 0) begin
                $display("%0t: result with no word pending: value %0d", $time, v);
                mismatches++;
                return;
            end
            e = owed.pop_front();
            if (v !== e.value) begin
                $display("%0t: value_out expected %0d actual %0d", $time, e.value, v);
                mismatches++;
            end
            if (u !== e.uniq) begin
                $display("%0t: is_unique expected %0b actual %0b (value %0d)",
                         $time, e.uniq, u, e.value);
                mismatches++;
            end
            if (c !== e.ucount) begin
                $display("%0t: unique_count expected %0d actual %0d (value %0d)",
                         $time, e.ucount, c, e.value);
                mismatches++;
            end
            if (o !== e.ovf) begin
                $display("%0t: overflow expected %0b actual %0b (value %0d)",
                         $time, e.ovf, o, e.value);
                mismatches++;
            end
            if (l !== e.lst) begin
                $display("%0t: last_out expected %0b actual %0b (value %0d)",
                         $time, e.lst, l, e.value);
                mismatches++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    word_t                        value;
    logic                         last;
    logic                         result_valid;
    word_t                        value_out;
    logic                         is_unique;
    logic [odf_pkg::UCOUNT_W-1:0] unique_count;
    logic                         overflow;
    logic                         last_out;

    dedup_tracker tracker;
    int           words_sent;
    int           cycles;

    order_preserving_dedup_filter #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .value_out    (value_out),
        .is_unique    (is_unique),
        .unique_count (unique_count),
        .overflow     (overflow),
        .last_out     (last_out)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
            tracker.check_result(value_out, is_unique, unique_count, overflow, last_out);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("order_preserving_dedup_filter: mismatch");
            $finish;
        end
    end

    // Offer one word and hold it until the block takes it
    task automatic send_word(word_t v, logic l);
        start <= 1'b1;
        value <= v;
        last  <= l;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_word(v, l);
        words_sent++;
    endtask

    // Drop start for a burst of cycles
    task automatic idle_for(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drop start and hold off until every owed result has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() > 0);
    endtask

    // Send one random set; repeats and extremes are mixed in with fresh words
    task automatic random_set(int len, int idle_pct);
        word_t sent_vals[$];
        word_t v;
        int    pick;
        int    i;
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 && sent_vals.size() > 0)
                v = sent_vals[$urandom_range(0, sent_vals.size() - 1)];
            else if (pick < 46) begin
                case ($urandom_range(0, 4))
                    0:       v = MOST_NEG;
                    1:       v = MOST_POS;
                    2:       v = 32'sd0;
                    3:       v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            else
                v = $urandom;
            sent_vals.push_back(v);
            if (words_sent < WORD_TARGET - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
                idle_for($urandom_range(1, 14));
            send_word(v, i == len - 1);
        end
    endtask

    initial
    begin
        int len;
        int idle_pct;
        int next_drain;

        tracker    = new();
        words_sent = 0;
        cycles     = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        value      = '0;
        last       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-word set on an empty table
        send_word(32'sd5, 1'b1);
        // Extremes, with repeats of MOST_NEG, MOST_POS and -1
        send_word(MOST_NEG, 1'b0);
        send_word(MOST_POS, 1'b0);
        send_word(32'sd0, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(MOST_NEG, 1'b0);
        send_word(MOST_POS, 1'b0);
        send_word(32'sh5555_5555, 1'b0);
        send_word(32'shAAAA_AAAA, 1'b0);
        send_word(-32'sd1, 1'b1);
        // Same word over and over
        send_word(32'sd7, 1'b0);
        send_word(32'sd7, 1'b0);
        send_word(32'sd7, 1'b1);
        // Set ending on a repeat
        send_word(32'sd1, 1'b0);
        send_word(32'sd1, 1'b1);
        // Word from the last set must be new again
        send_word(32'sd7, 1'b1);
        drain();

        // Random sets, mostly short, some long enough to overflow the table
        next_drain = 500;
        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(60, 100);
            else
                len = $urandom_range(1, 16);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 20;
                default: idle_pct = 60;
            endcase
            random_set(len, idle_pct);
            if (words_sent >= next_drain) begin
                drain();
                next_drain += 500;
            end
        end

        // Wait out the last results, then a little extra
        start <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("order_preserving_dedup_filter: match");
        else
            $display("order_preserving_dedup_filter: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/odf_pkg.sv
rtl/odf_ctrl.sv
rtl/odf_dp.sv
rtl/order_preserving_dedup_filter.sv
rtl/odf_checker.sv
tb/sv/tb_order_preserving_dedup_filter.sv
